// ===== src/motion_segment_sequencer_unit_macros.svh =====
// Assertion macros for the motion segment sequencer checker.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef MOTION_SEGMENT_SEQUENCER_UNIT_MACROS_SVH
`define MOTION_SEGMENT_SEQUENCER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define MSS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define MSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/mss_pkg.sv =====
// Shared types and constants for the motion segment sequencer.
// No dependencies; used by every module of the block.
package mss_pkg;

    // Command codes carried in the command field
    typedef enum logic [2:0] {
        CMD_PUSH   = 3'd0,
        CMD_START  = 3'd1,
        CMD_PAUSE  = 3'd2,
        CMD_RESUME = 3'd3,
        CMD_STOP   = 3'd4,
        CMD_ESTOP  = 3'd5,
        CMD_TICK   = 3'd6,
        CMD_CLEAR  = 3'd7
    } cmd_t;

    // Run state as shown on the result beat
    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_RUN   = 2'd1,
        MODE_PAUSE = 2'd2,
        MODE_ESTOP = 2'd3
    } mode_t;

    // Back end sequencer
    typedef enum logic {
        BK_EXEC = 1'b0,
        BK_LOAD = 1'b1
    } back_state_t;

    localparam int GOAL_IN   = 3;
    localparam int OPQ_DEPTH = 2;
    localparam int OPQ_AW    = $clog2(OPQ_DEPTH);

    // Input beat
    typedef struct packed {
        logic        [2:0]  command;
        logic        [15:0] seg_id;
        logic        [31:0] accel_len;
        logic        [31:0] cruise_len;
        logic        [31:0] decel_len;
        logic signed [31:0] goal_x;
        logic signed [31:0] goal_y;
        logic signed [31:0] goal_z;
    } in_t;

    // Result beat
    typedef struct packed {
        logic               push_ok;
        logic        [1:0]  run_state;
        logic               estop_alarm;
        logic        [3:0]  queued;
        logic               busy_res;
        logic        [15:0] active_id;
        logic               seg_done;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } out_t;

    // Decoded operation passed from front to back
    typedef struct packed {
        cmd_t                      cmd;
        logic [15:0]               seg_id;
        logic [31:0]               total;
        logic [GOAL_IN-1:0][31:0]  goal;
    } op_t;

    // Head of the operation queue as seen by the back end
    typedef struct packed {
        logic valid;
        op_t  op;
    } q_head_t;

endpackage

// ===== src/mss_front.sv =====
// Front end: accepts command beats, decodes them and sums the phase lengths.
// Depends on mss_pkg.
module mss_front (
    input  logic           cmd_valid,
    output logic           cmd_stall,
    input  mss_pkg::in_t   cmd,
    input  logic           q_full,
    output logic           q_push,
    output mss_pkg::op_t   q_op
);

    // Hold off the sender while the operation queue is full
    assign cmd_stall = q_full;
    assign q_push    = cmd_valid && !q_full;

    // Decode and precompute the segment total (wraps at 32 bits)
    always_comb
    begin
        q_op.cmd     = mss_pkg::cmd_t'(cmd.command);
        q_op.seg_id  = cmd.seg_id;
        q_op.total   = cmd.accel_len + cmd.cruise_len + cmd.decel_len;
        q_op.goal[0] = cmd.goal_x;
        q_op.goal[1] = cmd.goal_y;
        q_op.goal[2] = cmd.goal_z;
    end

endmodule

// ===== src/mss_opq.sv =====
// Short operation queue between the front and back ends.
// Depends on mss_pkg.
module mss_opq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  mss_pkg::op_t      push_op,
    output logic              full,
    output mss_pkg::q_head_t  head,
    input  logic              pop
);

    localparam int CW = mss_pkg::OPQ_AW + 1;

    mss_pkg::op_t                slot_reg [mss_pkg::OPQ_DEPTH];
    logic [mss_pkg::OPQ_AW-1:0]  wr_idx_reg, wr_idx_next;
    logic [mss_pkg::OPQ_AW-1:0]  rd_idx_reg, rd_idx_next;
    logic [CW-1:0]               cnt_reg, cnt_next;
    logic                        do_push, do_pop;

    assign full       = (cnt_reg == CW'(mss_pkg::OPQ_DEPTH));
    assign head.valid = (cnt_reg != '0);
    assign head.op    = slot_reg[rd_idx_reg];

    assign do_push = push && !full;
    assign do_pop  = pop && head.valid;

    // Pointer and fill count update
    always_comb
    begin
        wr_idx_next = wr_idx_reg;
        rd_idx_next = rd_idx_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_idx_next = (wr_idx_reg == mss_pkg::OPQ_AW'(mss_pkg::OPQ_DEPTH - 1)) ?
                          '0 : wr_idx_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_idx_next = (rd_idx_reg == mss_pkg::OPQ_AW'(mss_pkg::OPQ_DEPTH - 1)) ?
                          '0 : rd_idx_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_idx_reg <= wr_idx_next;
            rd_idx_reg <= rd_idx_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Payload slots
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_idx_reg] <= push_op;
        end
    end

endmodule

// ===== src/mss_back.sv =====
// Back end: segment ring queue, run-state machine, tick counter and result register.
// Depends on mss_pkg.
module mss_back #(
    parameter int SEG_DEPTH = 16,
    parameter int AXES      = 3
) (
    input  logic              clk,
    input  logic              rst_n,
    input  mss_pkg::q_head_t  head,
    output logic              pop,
    output logic              res_valid,
    input  logic              res_stall,
    output mss_pkg::out_t     res
);

    localparam int PW = (SEG_DEPTH > 1) ? $clog2(SEG_DEPTH) : 1;
    localparam int CW = PW + 1;
    localparam int GW = 32 * AXES;
    localparam int EW = 16 + 32 + GW;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PW'(SEG_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Segment store, one word per entry: goals, total, id
    logic [EW-1:0]             seg_mem [SEG_DEPTH];
    logic [EW-1:0]             rd_data_reg;
    logic [EW-1:0]             wr_word;
    logic [GW-1:0]             wr_goals;
    logic                      mem_we;

    mss_pkg::back_state_t      state_reg, state_next;
    mss_pkg::mode_t            mode_reg, mode_next;
    logic [PW-1:0]             wp_reg, wp_next;
    logic [PW-1:0]             rp_reg, rp_next;
    logic                      alarm_reg, alarm_next;
    logic                      active_reg, active_next;
    logic [15:0]               act_id_reg, act_id_next;
    logic [31:0]               act_total_reg, act_total_next;
    logic [31:0]               act_goal_reg [AXES];
    logic [31:0]               act_goal_next [AXES];
    logic [31:0]               tick_reg, tick_next;
    logic [31:0]               tick_inc;
    logic [31:0]               pos_reg [AXES];
    logic [31:0]               pos_next [AXES];
    logic                      res_valid_reg, res_valid_next;
    mss_pkg::out_t             res_reg, res_next;

    logic                      slot_free, take, needs_load, emit;
    logic                      push_ok, done;
    logic [CW-1:0]             count;
    logic [CW+3:0]             count_wide;
    logic [2:0][31:0]          pos_view;

    assign slot_free  = !res_valid_reg || !res_stall;
    assign take       = (state_reg == mss_pkg::BK_EXEC) && head.valid && slot_free;
    assign needs_load = (head.op.cmd == mss_pkg::CMD_TICK) && (mode_reg == mss_pkg::MODE_RUN)
                        && !active_reg && (wp_reg != rp_reg);
    assign pop        = take;
    assign tick_inc   = tick_reg + 32'd1;

    // Store word: axes beyond the input fields get a zero target
    for (genvar a = 0; a < AXES; a++)
    begin : g_wr_goal
        if (a < mss_pkg::GOAL_IN)
        begin : g_in
            assign wr_goals[32*a +: 32] = head.op.goal[a];
        end
        else
        begin : g_zero
            assign wr_goals[32*a +: 32] = '0;
        end
    end
    assign wr_word = {wr_goals, head.op.total, head.op.seg_id};

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mss_pkg::BK_EXEC:
            begin
                if (take && needs_load)
                begin
                    state_next = mss_pkg::BK_LOAD;
                end
            end
            mss_pkg::BK_LOAD:
            begin
                state_next = mss_pkg::BK_EXEC;
            end
            default:
            begin
                state_next = mss_pkg::BK_EXEC;
            end
        endcase
    end

    // Command execution
    always_comb
    begin
        mode_next      = mode_reg;
        wp_next        = wp_reg;
        rp_next        = rp_reg;
        alarm_next     = alarm_reg;
        active_next    = active_reg;
        act_id_next    = act_id_reg;
        act_total_next = act_total_reg;
        act_goal_next  = act_goal_reg;
        tick_next      = tick_reg;
        pos_next       = pos_reg;
        push_ok        = 1'b0;
        done           = 1'b0;
        emit           = 1'b0;
        mem_we         = 1'b0;
        if (state_reg == mss_pkg::BK_LOAD)
        begin
            // Load state of a loading tick: store data is now registered
            act_id_next    = rd_data_reg[15:0];
            act_total_next = rd_data_reg[47:16];
            for (int a = 0; a < AXES; a++)
            begin
                act_goal_next[a] = rd_data_reg[48 + 32*a +: 32];
            end
            rp_next     = ptr_inc(rp_reg);
            active_next = 1'b1;
            tick_next   = '0;
            emit        = 1'b1;
        end
        else if (take)
        begin
            emit = !needs_load;
            unique case (head.op.cmd)
                mss_pkg::CMD_PUSH:
                begin
                    if (ptr_inc(wp_reg) != rp_reg)
                    begin
                        mem_we  = 1'b1;
                        wp_next = ptr_inc(wp_reg);
                        push_ok = 1'b1;
                    end
                end
                mss_pkg::CMD_START:
                begin
                    if (mode_reg == mss_pkg::MODE_IDLE || mode_reg == mss_pkg::MODE_PAUSE)
                    begin
                        mode_next = mss_pkg::MODE_RUN;
                    end
                end
                mss_pkg::CMD_PAUSE:
                begin
                    if (mode_reg == mss_pkg::MODE_RUN)
                    begin
                        mode_next = mss_pkg::MODE_PAUSE;
                    end
                end
                mss_pkg::CMD_RESUME:
                begin
                    if (mode_reg == mss_pkg::MODE_PAUSE)
                    begin
                        mode_next = mss_pkg::MODE_RUN;
                    end
                end
                mss_pkg::CMD_STOP:
                begin
                    mode_next   = mss_pkg::MODE_IDLE;
                    wp_next     = '0;
                    rp_next     = '0;
                    active_next = 1'b0;
                end
                mss_pkg::CMD_ESTOP:
                begin
                    mode_next   = mss_pkg::MODE_ESTOP;
                    alarm_next  = 1'b1;
                    wp_next     = '0;
                    rp_next     = '0;
                    active_next = 1'b0;
                end
                mss_pkg::CMD_TICK:
                begin
                    if (mode_reg == mss_pkg::MODE_RUN)
                    begin
                        if (active_reg)
                        begin
                            tick_next = tick_inc;
                            if (tick_inc >= act_total_reg)
                            begin
                                pos_next    = act_goal_reg;
                                active_next = 1'b0;
                                done        = 1'b1;
                            end
                        end
                        else if (wp_reg == rp_reg)
                        begin
                            // nothing queued: drop back to idle
                            mode_next = mss_pkg::MODE_IDLE;
                        end
                    end
                end
                mss_pkg::CMD_CLEAR:
                begin
                    wp_next = '0;
                    rp_next = '0;
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end
    end

    // Queue fill level, modulo depth, shown as four bits
    assign count      = ({1'b0, wp_next} - {1'b0, rp_next})
                        + ((wp_next < rp_next) ? CW'(SEG_DEPTH) : '0);
    assign count_wide = {4'b0, count};

    for (genvar a = 0; a < 3; a++)
    begin : g_pos_view
        if (a < AXES)
        begin : g_axis
            assign pos_view[a] = pos_next[a];
        end
        else
        begin : g_none
            assign pos_view[a] = '0;
        end
    end

    // Result beat from the post-command state
    always_comb
    begin
        res_next.push_ok     = push_ok;
        res_next.run_state   = mode_next;
        res_next.estop_alarm = alarm_next;
        res_next.queued      = count_wide[3:0];
        res_next.busy_res    = active_next;
        res_next.active_id   = act_id_next;
        res_next.seg_done    = done;
        res_next.pos_x       = pos_view[0];
        res_next.pos_y       = pos_view[1];
        res_next.pos_z       = pos_view[2];
        res_valid_next       = emit ? 1'b1 : (res_valid_reg && res_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mss_pkg::BK_EXEC;
            mode_reg      <= mss_pkg::MODE_IDLE;
            wp_reg        <= '0;
            rp_reg        <= '0;
            alarm_reg     <= 1'b0;
            active_reg    <= 1'b0;
            act_id_reg    <= '0;
            act_total_reg <= '0;
            tick_reg      <= '0;
            res_valid_reg <= 1'b0;
            for (int a = 0; a < AXES; a++)
            begin
                act_goal_reg[a] <= '0;
                pos_reg[a]      <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            alarm_reg     <= alarm_next;
            active_reg    <= active_next;
            act_id_reg    <= act_id_next;
            act_total_reg <= act_total_next;
            tick_reg      <= tick_next;
            res_valid_reg <= res_valid_next;
            act_goal_reg  <= act_goal_next;
            pos_reg       <= pos_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            res_reg <= res_next;
        end
    end

    // Segment store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            seg_mem[wp_reg] <= wr_word;
        end
        rd_data_reg <= seg_mem[rp_reg];
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ===== src/motion_segment_sequencer_unit.sv =====
// Motion segment sequencer, top level.
// Command channel (cmd_valid / cmd_stall / cmd) takes one beat per cycle while
// cmd_stall is low: push, start, pause, resume, stop, estop, tick or clear.
// Each command gives exactly one result beat on the result channel (res_valid /
// res_stall / res) showing the state after that command.
// An accepted command beat is written into the operation queue, taken from its head
// by the back end and registered in the result register that drives res_valid. A
// tick that loads a new segment holds the back end in the load state, where it takes
// no command, because the segment store has a registered read port.
// Reset (rst_n low, asynchronous): queue empty, run state idle, alarm clear, no
// active segment, positions and active id zero. No clearing pass is needed.
// A stalled result is held unchanged; the operation queue between the front and
// back ends absorbs two further commands before cmd_stall is raised.
// Depends on mss_pkg, mss_front, mss_opq and mss_back.
module motion_segment_sequencer_unit #(
    parameter int SEG_DEPTH = 16,
    parameter int AXES      = 3
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_stall,
    input  mss_pkg::in_t   cmd,
    output logic           res_valid,
    input  logic           res_stall,
    output mss_pkg::out_t  res
);

    logic              q_full;
    logic              q_push;
    logic              q_pop;
    mss_pkg::op_t      q_op;
    mss_pkg::q_head_t  q_head;

    mss_front u_front (
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_op      (q_op)
    );

    mss_opq u_opq (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_op (q_op),
        .full    (q_full),
        .head    (q_head),
        .pop     (q_pop)
    );

    mss_back #(
        .SEG_DEPTH (SEG_DEPTH),
        .AXES      (AXES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .pop       (q_pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule

// ===== src/mss_checker.sv =====
// Port-level checks for the motion segment sequencer, bound to the top level.
// Depends on mss_pkg and motion_segment_sequencer_unit_macros.svh.
`include "motion_segment_sequencer_unit_macros.svh"

module mss_port_checks (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           res_valid,
    input  logic           res_stall,
    input  mss_pkg::out_t  res
);

    // A stalled result beat stays put
    `MSS_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res), "stalled result beat changed")

    // Alarm only clears on reset
    `MSS_ASSERT_NEXT(a_alarm_sticky, res_valid && res.estop_alarm, !res_valid || res.estop_alarm, "estop alarm cleared")

    // Estop state always carries the alarm
    `MSS_ASSERT_NOW(a_estop_alarm, res_valid && (res.run_state == mss_pkg::MODE_ESTOP), res.estop_alarm, "estop without alarm")

    // No active segment in idle or estop
    `MSS_ASSERT_NOW(a_idle_not_busy, res_valid && (res.run_state == mss_pkg::MODE_IDLE || res.run_state == mss_pkg::MODE_ESTOP), !res.busy_res, "active segment outside run or pause")

    // Completion only while running, and it releases the segment
    `MSS_ASSERT_NOW(a_done_run, res_valid && res.seg_done, !res.busy_res && (res.run_state == mss_pkg::MODE_RUN), "segment done outside running")

endmodule

bind motion_segment_sequencer_unit mss_port_checks u_mss_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
);
